@@ hdl/cdrv_pkg.sv @@
// ----------------------------------------------------------------------------
// CORDIC degree package
// Shared widths, codes, the arctangent table in degrees times 256, and the
// step control type used by the sequencer and the shared micro-rotation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cdrv_pkg;

   // Internal datapath widths. The x/y path holds the 3D magnitude with gain.
   localparam int DATA_W      = 28;
   localparam int ANG_W       = 18;
   localparam int OUT_W       = 25;
   localparam int IN_W        = 16;
   localparam int CFG_W       = 15;
   localparam int DEG_W       = 9;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int TBL_IDX_W   = 4;
   localparam int TBL_DEPTH   = 16;
   localparam int SCALE_SHIFT = 8;
   localparam int GAIN_FRAC   = 15;

   // Default for the number of micro-rotations.
   localparam int ITERATIONS_DEF = 16;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ANG_W-1:0]  angle_type;
   typedef logic signed [OUT_W-1:0]  out_type;

   // Operating modes.
   localparam logic [MODE_W-1:0] MODE_ROTATE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VECTOR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ELEV   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 1'b1;

   localparam logic [CFG_W-1:0] INIT_X_RESET = 15'd19898;
   localparam logic [CFG_W-1:0] GAIN_RESET   = 15'd19898;

   // Degree thresholds and quadrant bases.
   localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
   localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
   localparam logic [DEG_W-1:0] DEG_360 = 9'd360;
   localparam angle_type ACC_180 = angle_type'(180 * 256);
   localparam angle_type ACC_360 = angle_type'(360 * 256);

   // Arctangent of 2^-i in degrees times 256.
   localparam angle_type ATAN_TABLE [0:TBL_DEPTH-1] = '{
      18'sd11520, 18'sd6801, 18'sd3593, 18'sd1824, 18'sd916, 18'sd458,
      18'sd229,   18'sd115,  18'sd57,   18'sd29,   18'sd14,  18'sd7,
      18'sd4,     18'sd2,    18'sd1,    18'sd0
   };

   localparam data_type OUT_MAX_D = data_type'(2 ** (OUT_W - 1) - 1);
   localparam data_type OUT_MIN_D = data_type'(-(2 ** (OUT_W - 1)));

   // Direction of one micro-rotation and of the angle update.
   typedef struct packed {
      logic ccw;
      logic ang_add;
   } step_ctrl_type;

   // Clamp an internal value to the result range.
   function automatic out_type sat_out(input data_type v);
      out_type r;
      if (v > OUT_MAX_D) begin
         r = out_type'(OUT_MAX_D);
      end else if (v < OUT_MIN_D) begin
         r = out_type'(OUT_MIN_D);
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/cdrv_step.sv @@
// ----------------------------------------------------------------------------
// CORDIC micro-rotation unit
// One shift-add step on x, y and the angle accumulator, shared by every
// iteration of every pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrv_step
   import cdrv_pkg::*;
(
   input  data_type               x_cur,
   input  data_type               y_cur,
   input  angle_type              a_cur,
   input  logic [TBL_IDX_W-1:0]   idx,
   input  step_ctrl_type          ctrl,
   output data_type               x_nxt,
   output data_type               y_nxt,
   output angle_type              a_nxt
);

   data_type sx;
   data_type sy;

   // Arithmetic shifts by the iteration number.
   assign sx = x_cur >>> idx;
   assign sy = y_cur >>> idx;

   // Rotate counterclockwise or clockwise.
   assign x_nxt = ctrl.ccw ? (x_cur - sy) : (x_cur + sy);
   assign y_nxt = ctrl.ccw ? (y_cur + sx) : (y_cur - sx);

   // Track the angle turned so far.
   assign a_nxt = ctrl.ang_add ? (a_cur + ATAN_TABLE[idx]) : (a_cur - ATAN_TABLE[idx]);

endmodule

`default_nettype wire

@@ hdl/cdrv_gain.sv @@
// ----------------------------------------------------------------------------
// CORDIC gain correction
// Multiplies the magnitude by the Q15 gain and drops the fraction, rounding
// towards minus infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrv_gain
   import cdrv_pkg::*;
(
   input  data_type             x_val,
   input  logic [CFG_W-1:0]     gain,
   output data_type             x_scaled
);

   localparam int PROD_W = DATA_W + CFG_W + 1;

   logic signed [PROD_W-1:0] prod;

   // Signed product with the gain taken as a positive value.
   assign prod = PROD_W'(x_val) * PROD_W'($signed({1'b0, gain}));

   // The scaled magnitude always fits the internal width.
   assign x_scaled = prod[GAIN_FRAC +: DATA_W];

endmodule

`default_nettype wire

@@ hdl/cordic_degree_rotate_vector.sv @@
// Sequence: modes 0 and 1 run one pass of the shared unit and then a finish step,
// mode 2 runs two passes of the shared unit, a gain step after each and a setup
// step between, and the unused mode strobes its result in the very next cycle.
// Throughput: busy drops in the strobe cycle, so a new item can be taken from the
// strobe cycle on, and an unused-mode item never raises busy. The receiver cannot
// stall results. Reset clears the sequencer and strobe and loads both registers.
// ----------------------------------------------------------------------------
// CORDIC rotate and vector, degree units
// Sequencer around one shared micro-rotation unit and one gain multiplier,
// giving sine/cosine, azimuth/magnitude, or elevation/3D magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module cordic_degree_rotate_vector
   import cdrv_pkg::*;
#(
   parameter int ITERATIONS = ITERATIONS_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic [DEG_W-1:0]        req_angle_deg,
   input  logic signed [IN_W-1:0]  req_x_in,
   input  logic signed [IN_W-1:0]  req_y_in,
   input  logic signed [IN_W-1:0]  req_z_in,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_x_out,
   output logic signed [OUT_W-1:0] rsp_y_out,
   output logic signed [ANG_W-1:0] rsp_angle_theta,
   output logic signed [ANG_W-1:0] rsp_angle_phi,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_wdata
);

   localparam int CNT_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITERATIONS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ITER,
      ST_FINISH,
      ST_SETUP2
   } state_type;

   typedef struct packed {
      data_type  x;
      data_type  y;
      angle_type a;
   } fold_type;

   // Move a vector into the right half plane and pick the angle base.
   function automatic fold_type fold_vec(input data_type xi, input data_type yi);
      fold_type f;
      if (xi < 0) begin
         f.x = -xi;
         f.y = -yi;
         f.a = ACC_180;
      end else if (yi < 0) begin
         f.x = xi;
         f.y = yi;
         f.a = ACC_360;
      end else begin
         f.x = xi;
         f.y = yi;
         f.a = '0;
      end
      return f;
   endfunction

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   data_type         x_ff, x_in;
   data_type         y_ff, y_in;
   angle_type        a_ff, a_in;
   angle_type        target_ff, target_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic             flip_ff, flip_in;
   logic             pass2_ff, pass2_in;
   logic signed [IN_W-1:0] z_ff, z_in;
   angle_type        theta_hold_ff, theta_hold_in;
   out_type          yhold_ff, yhold_in;
   logic [CFG_W-1:0] init_x_ff, init_x_in;
   logic [CFG_W-1:0] gain_ff, gain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   out_type          rsp_x_ff, rsp_x_in;
   out_type          rsp_y_ff, rsp_y_in;
   angle_type        rsp_theta_ff, rsp_theta_in;
   angle_type        rsp_phi_ff, rsp_phi_in;

   step_ctrl_type    step_ctrl;
   data_type         step_x, step_y;
   angle_type        step_a;
   data_type         gain_x;
   fold_type         fold_req, fold_z;
   logic [DEG_W-1:0] deg_red;
   logic             accept;

   // Shared micro-rotation unit.
   cdrv_step u_step (
      .x_cur (x_ff),
      .y_cur (y_ff),
      .a_cur (a_ff),
      .idx   (TBL_IDX_W'(cnt_ff)),
      .ctrl  (step_ctrl),
      .x_nxt (step_x),
      .y_nxt (step_y),
      .a_nxt (step_a)
   );

   // Shared gain multiplier.
   cdrv_gain u_gain (
      .x_val    (x_ff),
      .gain     (gain_ff),
      .x_scaled (gain_x)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Rotation direction: steer the angle in rotation, steer y to zero otherwise.
   always_comb begin
      if (mode_ff == MODE_ROTATE) begin
         step_ctrl.ang_add = (target_ff > a_ff);
         step_ctrl.ccw     = (target_ff > a_ff);
      end else begin
         step_ctrl.ang_add = (y_ff > 0);
         step_ctrl.ccw     = !(y_ff > 0);
      end
   end

   // Setup values for a new item and for the elevation pass.
   assign fold_req = fold_vec(data_type'(req_x_in) <<< SCALE_SHIFT,
                              data_type'(req_y_in) <<< SCALE_SHIFT);
   assign fold_z   = fold_vec(x_ff, data_type'(z_ff) <<< SCALE_SHIFT);
   assign deg_red  = (req_angle_deg >= DEG_360) ? (req_angle_deg - DEG_360) : req_angle_deg;

   // Sequencer next-state and datapath loads.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      a_in          = a_ff;
      target_in     = target_ff;
      mode_in       = mode_ff;
      flip_in       = flip_ff;
      pass2_in      = pass2_ff;
      z_in          = z_ff;
      theta_hold_in = theta_hold_ff;
      yhold_in      = yhold_ff;
      init_x_in     = init_x_ff;
      gain_in       = gain_ff;
      rsp_valid_in  = 1'b0;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_theta_in  = rsp_theta_ff;
      rsp_phi_in    = rsp_phi_ff;

      // Register writes.
      if (csr_valid) begin
         case (csr_index)
            CSR_INIT_X: init_x_in = csr_wdata;
            CSR_GAIN:   gain_in   = csr_wdata;
            default:    ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               z_in     = req_z_in;
               cnt_in   = '0;
               pass2_in = 1'b0;
               flip_in  = (deg_red > DEG_90) && (deg_red <= DEG_270);
               case (req_mode)
                  MODE_ROTATE: begin
                     x_in      = data_type'({1'b0, init_x_ff});
                     y_in      = '0;
                     target_in = angle_type'({1'b0, deg_red, {SCALE_SHIFT{1'b0}}});
                     if (deg_red > DEG_270) begin
                        a_in = ACC_360;
                     end else if (deg_red > DEG_90) begin
                        a_in = ACC_180;
                     end else begin
                        a_in = '0;
                     end
                     state_in = ST_ITER;
                  end
                  MODE_VECTOR, MODE_ELEV: begin
                     x_in     = fold_req.x;
                     y_in     = fold_req.y;
                     a_in     = fold_req.a;
                     state_in = ST_ITER;
                  end
                  default: begin
                     // Unused mode: one all-zero result.
                     rsp_valid_in = 1'b1;
                     rsp_x_in     = '0;
                     rsp_y_in     = '0;
                     rsp_theta_in = '0;
                     rsp_phi_in   = '0;
                  end
               endcase
            end
         end

         ST_ITER: begin
            x_in   = step_x;
            y_in   = step_y;
            a_in   = step_a;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (mode_ff == MODE_ROTATE) begin
               // Quadrants 2 and 3 negate cosine and sine.
               rsp_valid_in = 1'b1;
               rsp_x_in     = sat_out(flip_ff ? -x_ff : x_ff);
               rsp_y_in     = sat_out(flip_ff ? -y_ff : y_ff);
               rsp_theta_in = '0;
               rsp_phi_in   = '0;
               state_in     = ST_IDLE;
            end else if (pass2_ff) begin
               // End of the elevation pass.
               rsp_valid_in = 1'b1;
               rsp_x_in     = sat_out(gain_x);
               rsp_y_in     = yhold_ff;
               rsp_theta_in = theta_hold_ff;
               rsp_phi_in   = a_ff;
               state_in     = ST_IDLE;
            end else if (mode_ff == MODE_ELEV) begin
               // Keep the azimuth results and chain the magnitude on.
               theta_hold_in = a_ff;
               yhold_in      = sat_out(y_ff);
               x_in          = gain_x;
               state_in      = ST_SETUP2;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = sat_out(gain_x);
               rsp_y_in     = sat_out(y_ff);
               rsp_theta_in = a_ff;
               rsp_phi_in   = '0;
               state_in     = ST_IDLE;
            end
         end

         ST_SETUP2: begin
            x_in     = fold_z.x;
            y_in     = fold_z.y;
            a_in     = fold_z.a;
            cnt_in   = '0;
            pass2_in = 1'b1;
            state_in = ST_ITER;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         init_x_ff    <= INIT_X_RESET;
         gain_ff      <= GAIN_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         init_x_ff    <= init_x_in;
         gain_ff      <= gain_in;
      end
      cnt_ff        <= cnt_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      a_ff          <= a_in;
      target_ff     <= target_in;
      mode_ff       <= mode_in;
      flip_ff       <= flip_in;
      pass2_ff      <= pass2_in;
      z_ff          <= z_in;
      theta_hold_ff <= theta_hold_in;
      yhold_ff      <= yhold_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_theta_ff  <= rsp_theta_in;
      rsp_phi_ff    <= rsp_phi_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_out       = rsp_x_ff;
   assign rsp_y_out       = rsp_y_ff;
   assign rsp_angle_theta = rsp_theta_ff;
   assign rsp_angle_phi   = rsp_phi_ff;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CORDIC rotate and vector testbench
// Drives sine/cosine, azimuth/magnitude and elevation items through the
// command port, predicts every result with a bit-true CORDIC model held in
// the testbench, and checks each strobed result against the oldest
// prediction. Both registers are rewritten between phases while the block
// is idle, covering the extremes and random settings.
// ----------------------------------------------------------------------------

module tb;
   import cdrv_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int STEPS        = ITERATIONS_DEF;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 241;
   localparam int SETTLE_CYC   = 40;

   // One entry of the stimulus list: an item, a register write, or a pause
   // until the block has returned every result.
   typedef enum logic [1:0] {ACT_ITEM, ACT_CSR, ACT_DRAIN} act_kind_type;

   typedef struct {
      act_kind_type           kind;
      bit                     may_idle;
      logic [MODE_W-1:0]      mode;
      logic [DEG_W-1:0]       deg;
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CFG_W-1:0]       data;
   } cordic_action_type;

   typedef struct packed {
      out_type   x;
      out_type   y;
      angle_type theta;
      angle_type phi;
   } cordic_result_type;

   // Block ports.
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [MODE_W-1:0]       req_mode = '0;
   logic [DEG_W-1:0]        req_angle_deg = '0;
   logic signed [IN_W-1:0]  req_x_in = '0;
   logic signed [IN_W-1:0]  req_y_in = '0;
   logic signed [IN_W-1:0]  req_z_in = '0;
   logic                    rsp_valid;
   logic signed [OUT_W-1:0] rsp_x_out;
   logic signed [OUT_W-1:0] rsp_y_out;
   logic signed [ANG_W-1:0] rsp_angle_theta;
   logic signed [ANG_W-1:0] rsp_angle_phi;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CFG_W-1:0]        csr_wdata = '0;

   // Testbench state.
   cordic_action_type cordic_requests[$];
   cordic_result_type cordic_results_due[$];
   logic [CFG_W-1:0] cfg_init_x = INIT_X_RESET;
   logic [CFG_W-1:0] cfg_gain   = GAIN_RESET;
   int n_sent     = 0;
   int n_done     = 0;
   int idle_left  = 0;
   int mismatches = 0;

   cordic_degree_rotate_vector u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_angle_deg   (req_angle_deg),
      .req_x_in        (req_x_in),
      .req_y_in        (req_y_in),
      .req_z_in        (req_z_in),
      .rsp_valid       (rsp_valid),
      .rsp_x_out       (rsp_x_out),
      .rsp_y_out       (rsp_y_out),
      .rsp_angle_theta (rsp_angle_theta),
      .rsp_angle_phi   (rsp_angle_phi),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #1000000;
      $display("end of test: mismatches");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic out_type clamp_result(input longint v);
      longint c;
      c = v;
      if (c > 64'sd16777215) begin
         c = 64'sd16777215;
      end else if (c < -64'sd16777216) begin
         c = -64'sd16777216;
      end
      return out_type'(c);
   endfunction

   // Q15 gain correction, floor rounding.
   function automatic longint scale_by_gain(input longint v);
      longint g;
      g = cfg_gain;
      return (v * g) >>> GAIN_FRAC;
   endfunction

   // One vectoring pass: fold into the right half plane, then drive y to zero.
   function automatic void vector_pass(inout longint px, inout longint py,
                                       output longint pang);
      longint vx, vy, va, sx, sy;
      vx = px;
      vy = py;
      if (vx < 0) begin
         va = 180 * 256;
         vx = -vx;
         vy = -vy;
      end else if (vy < 0) begin
         va = 360 * 256;
      end else begin
         va = 0;
      end
      for (int i = 0; i < STEPS; i++) begin
         sx = vx >>> (i % TBL_DEPTH);
         sy = vy >>> (i % TBL_DEPTH);
         if (vy > 0) begin
            vx = vx + sy;
            vy = vy - sx;
            va = va + ATAN_TABLE[i % TBL_DEPTH];
         end else begin
            vx = vx - sy;
            vy = vy + sx;
            va = va - ATAN_TABLE[i % TBL_DEPTH];
         end
      end
      px = vx;
      py = vy;
      pang = va;
   endfunction

   function automatic cordic_result_type cordic_predict(
      input logic [MODE_W-1:0] mode, input logic [DEG_W-1:0] deg,
      input logic signed [IN_W-1:0] xi, input logic signed [IN_W-1:0] yi,
      input logic signed [IN_W-1:0] zi);
      cordic_result_type r;
      longint d, acc, tgt, vx, vy, vz, sx, sy, th, ph;
      r = '0;
      if (mode == MODE_ROTATE) begin
         // Reduce the angle, pick the quadrant base and rotate from (init_x, 0).
         d = deg;
         if (d >= 360) begin
            d = d - 360;
         end
         acc = 0;
         if (d > 90) begin
            acc = 180 * 256;
         end
         if (d > 270) begin
            acc = 360 * 256;
         end
         tgt = d * 256;
         vx = cfg_init_x;
         vy = 0;
         for (int i = 0; i < STEPS; i++) begin
            sx = vx >>> (i % TBL_DEPTH);
            sy = vy >>> (i % TBL_DEPTH);
            if (tgt > acc) begin
               acc = acc + ATAN_TABLE[i % TBL_DEPTH];
               vx = vx - sy;
               vy = vy + sx;
            end else begin
               acc = acc - ATAN_TABLE[i % TBL_DEPTH];
               vx = vx + sy;
               vy = vy - sx;
            end
         end
         // The second and third quadrants come out negated.
         if (d > 90 && d <= 270) begin
            vx = -vx;
            vy = -vy;
         end
         r.x = clamp_result(vx);
         r.y = clamp_result(vy);
      end else if (mode == MODE_VECTOR || mode == MODE_ELEV) begin
         vx = longint'(xi) * 256;
         vy = longint'(yi) * 256;
         vector_pass(vx, vy, th);
         vx = scale_by_gain(vx);
         r.y = clamp_result(vy);
         r.theta = angle_type'(th);
         // The elevation pass starts from the unclamped magnitude.
         if (mode == MODE_ELEV) begin
            vz = longint'(zi) * 256;
            vector_pass(vx, vz, ph);
            vx = scale_by_gain(vx);
            r.phi = angle_type'(ph);
         end
         r.x = clamp_result(vx);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus list
   // ---------------------------------------------------------------------

   function automatic void add_item(input logic [MODE_W-1:0] m,
                                    input logic [DEG_W-1:0] a,
                                    input logic signed [IN_W-1:0] x,
                                    input logic signed [IN_W-1:0] y,
                                    input logic signed [IN_W-1:0] z,
                                    input bit idle);
      cordic_action_type act;
      act = '{kind: ACT_ITEM, may_idle: idle, mode: m, deg: a, x: x, y: y, z: z,
              idx: '0, data: '0};
      cordic_requests.push_back(act);
   endfunction

   function automatic void add_control(input act_kind_type k,
                                       input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
      cordic_action_type act;
      act = '{kind: k, may_idle: 1'b0, mode: '0, deg: '0, x: '0, y: '0, z: '0,
              idx: idx, data: data};
      cordic_requests.push_back(act);
   endfunction

   // Coordinates lean on the corners of the range and on tiny vectors.
   function automatic logic signed [IN_W-1:0] rand_coord();
      logic signed [IN_W-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = 16'sh7FFF;
         1:       v = 16'sh8000;
         2:       v = '0;
         3:       v = 16'($urandom_range(0, 31)) - 16'sd16;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   function automatic void add_random_item(input bit idle);
      logic [MODE_W-1:0] m;
      logic [DEG_W-1:0]  a;
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         m = MODE_UNUSED;
      end else if (pick <= 5) begin
         m = MODE_ROTATE;
      end else if (pick <= 10) begin
         m = MODE_VECTOR;
      end else begin
         m = MODE_ELEV;
      end
      if ($urandom_range(0, 9) == 0) begin
         a = 9'($urandom_range(360, 511));
      end else begin
         a = 9'($urandom_range(0, 359));
      end
      add_item(m, a, rand_coord(), rand_coord(), rand_coord(), idle);
   endfunction

   initial begin : stimulus
      logic [CFG_W-1:0] phase_init [0:PHASES-1];
      logic [CFG_W-1:0] phase_gain [0:PHASES-1];
      bit idle;

      // Directed items under the reset settings: quadrant edges, wrapped
      // angles, range corners, zero vectors and the unused mode.
      add_item(MODE_ROTATE, 9'd0,   '0, '0, '0, 1'b1);
      add_item(MODE_ROTATE, 9'd45,  '0, '0, '0, 1'b1);
      add_item(MODE_ROTATE, 9'd90,  '0, '0, '0, 1'b1);
      add_item(MODE_ROTATE, 9'd91,  '0, '0, '0, 1'b1);
      add_item(MODE_ROTATE, 9'd180, '0, '0, '0, 1'b1);
      add_item(MODE_ROTATE, 9'd270, '0, '0, '0, 1'b1);
      add_item(MODE_ROTATE, 9'd271, '0, '0, '0, 1'b1);
      add_item(MODE_ROTATE, 9'd359, '0, '0, '0, 1'b1);
      add_item(MODE_ROTATE, 9'd360, '0, '0, '0, 1'b1);
      add_item(MODE_ROTATE, 9'd511, '0, '0, '0, 1'b1);
      add_item(MODE_VECTOR, '0, 16'sh7FFF, 16'sh7FFF, '0, 1'b1);
      add_item(MODE_VECTOR, '0, 16'sh8000, 16'sh8000, '0, 1'b1);
      add_item(MODE_VECTOR, '0, 16'sh7FFF, 16'sh8000, '0, 1'b1);
      add_item(MODE_VECTOR, '0, 16'sh8000, 16'sh7FFF, '0, 1'b1);
      add_item(MODE_VECTOR, '0, '0, '0, '0, 1'b1);
      add_item(MODE_VECTOR, '0, -16'sd1, '0, '0, 1'b1);
      add_item(MODE_VECTOR, '0, '0, -16'sd1, '0, 1'b1);
      add_item(MODE_ELEV, '0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
      add_item(MODE_ELEV, '0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
      add_item(MODE_ELEV, '0, '0, '0, '0, 1'b1);
      add_item(MODE_ELEV, '0, 16'sd100, -16'sd200, 16'sh8000, 1'b1);
      add_item(MODE_UNUSED, 9'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 1'b1);
      add_item(MODE_UNUSED, 9'h1FF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b1);

      // Register settings per phase: reset values, extremes, then random.
      phase_init[0] = INIT_X_RESET;  phase_gain[0] = GAIN_RESET;
      phase_init[1] = 15'h7FFF;      phase_gain[1] = 15'h7FFF;
      phase_init[2] = 15'h0000;      phase_gain[2] = 15'h0000;
      phase_init[3] = 15'h7FFF;      phase_gain[3] = 15'h0000;
      phase_init[4] = 15'h0000;      phase_gain[4] = 15'h7FFF;
      phase_init[5] = 15'd1;         phase_gain[5] = 15'd16384;
      phase_init[6] = 15'($urandom); phase_gain[6] = 15'($urandom);
      phase_init[7] = 15'($urandom); phase_gain[7] = 15'($urandom);

      for (int p = 0; p < PHASES; p++) begin
         add_control(ACT_CSR, CSR_INIT_X, phase_init[p]);
         add_control(ACT_CSR, CSR_GAIN, phase_gain[p]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // Runs of back-to-back items between idle stretches; the last
            // phase runs flat out.
            idle = (p != PHASES - 1) && (((k / 40) % 3) != 2);
            if (k == PHASE_ITEMS / 2) begin
               add_control(ACT_DRAIN, '0, '0);
            end
            add_random_item(idle);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Sample at the falling edge so that every update of the edge is in.
      do begin
         @(negedge clock);
      end while (cordic_requests.size() != 0 || start || csr_valid ||
                 n_sent != n_done);
      repeat (SETTLE_CYC) @(posedge clock);

      if (cordic_results_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived",
                                   cordic_results_due.size()));
      end
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: issues items, register writes and drain pauses in list order.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      cordic_action_type act;
      logic start_nxt;
      logic csr_nxt;
      logic settled;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         idle_left = 0;
      end else begin
         start_nxt = start && busy;
         csr_nxt = csr_valid && !csr_ready;
         settled = !start && !busy && !csr_valid && (n_sent == n_done);
         if (!start_nxt && !csr_nxt) begin
            if (idle_left > 0) begin
               // Idle cycles count only once the block can take an item.
               if (!busy) begin
                  idle_left--;
               end
            end else if (cordic_requests.size() > 0) begin
               act = cordic_requests[0];
               if (act.kind == ACT_ITEM) begin
                  void'(cordic_requests.pop_front());
                  start_nxt = 1'b1;
                  req_mode <= act.mode;
                  req_angle_deg <= act.deg;
                  req_x_in <= act.x;
                  req_y_in <= act.y;
                  req_z_in <= act.z;
                  if (act.may_idle && $urandom_range(0, 2) == 0) begin
                     idle_left = $urandom_range(1, 16);
                  end
               end else if (settled) begin
                  // Writes and drain pauses wait for an empty block.
                  void'(cordic_requests.pop_front());
                  if (act.kind == ACT_CSR) begin
                     csr_nxt = 1'b1;
                     csr_index <= act.idx;
                     csr_wdata <= act.data;
                  end
               end
            end
         end
         start <= start_nxt;
         csr_valid <= csr_nxt;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks results, tracks register writes, predicts each item.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      cordic_result_type got;
      cordic_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            got.x = rsp_x_out;
            got.y = rsp_y_out;
            got.theta = rsp_angle_theta;
            got.phi = rsp_angle_phi;
            if (cordic_results_due.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none expected", n_done));
            end else begin
               want = cordic_results_due.pop_front();
               if (got.x !== want.x) begin
                  report_mismatch($sformatf("result %0d x_out %0d, expected %0d",
                                            n_done, got.x, want.x));
               end
               if (got.y !== want.y) begin
                  report_mismatch($sformatf("result %0d y_out %0d, expected %0d",
                                            n_done, got.y, want.y));
               end
               if (got.theta !== want.theta) begin
                  report_mismatch($sformatf("result %0d angle_theta %0d, expected %0d",
                                            n_done, got.theta, want.theta));
               end
               if (got.phi !== want.phi) begin
                  report_mismatch($sformatf("result %0d angle_phi %0d, expected %0d",
                                            n_done, got.phi, want.phi));
               end
            end
            n_done <= n_done + 1;
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INIT_X: cfg_init_x = csr_wdata;
               CSR_GAIN:   cfg_gain = csr_wdata;
               default:    ;
            endcase
         end

         if (start && !busy) begin
            cordic_results_due.push_back(cordic_predict(req_mode, req_angle_deg,
                                                        req_x_in, req_y_in, req_z_in));
            n_sent <= n_sent + 1;
         end
      end
   end

endmodule
